[hdl/plc_pkg.sv]
package plc_pkg;

   localparam int BUCKETS = 256;
   localparam int WAYS    = 16;
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int WAY_W   = $clog2(WAYS);
   localparam int CNT_W   = WAY_W + 1;
   localparam int PROTO_W = 8;
   localparam int PORT_W  = 16;
   localparam int KEY_W   = PROTO_W + PORT_W;
   localparam int LBL_W   = 32;
   localparam int FUNC_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LBL_W-1:0] label;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [WAY_W-1:0] oldest;
   } meta_type;

   typedef struct packed {
      logic rd_en;
      logic commit;
      logic wr_fill;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic              hit;
      logic [FUNC_W-1:0] func;
   } sts_type;

endpackage

[hdl/plc_ctrl.sv]
module plc_ctrl
   import plc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               cmd.wr_fill  = (sts.func == FUNC_FILL) && !sts.hit;
               cmd.flush    = (sts.func == FUNC_FLUSH);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/plc_datapath.sv]
module plc_datapath
   import plc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PROTO_W-1:0] req_protocol,
   input  logic [PORT_W-1:0]  req_port,
   input  logic [LBL_W-1:0]   req_fill_label,
   output logic               rsp_found,
   output logic [LBL_W-1:0]   rsp_label
);

   row_type  mem_rows [BUCKETS];
   meta_type mem_meta [BUCKETS];

   logic [BUCKETS-1:0] meta_valid_ff, meta_valid_in;

   logic [FUNC_W-1:0] func_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [BKT_W-1:0]  bkt_ff;
   logic [LBL_W-1:0]  fill_label_ff;
   row_type           row_rd_ff;
   meta_type          meta_rd_ff;
   logic              mvalid_ff;

   logic              found_ff, found_in;
   logic [LBL_W-1:0]  label_ff, label_in;

   meta_type          meta_cur;
   meta_type          meta_wr;
   row_type           row_wr;
   logic [WAYS-1:0]   match;
   logic [LBL_W-1:0]  hit_label;
   logic              hit;
   logic [WAY_W-1:0]  ins_way;

   assign meta_cur = mvalid_ff ? meta_rd_ff : '0;

   always_comb begin
      logic [WAY_W-1:0] offs;
      hit_label = '0;
      for (int w = 0; w < WAYS; w++) begin
         offs      = WAY_W'(w) - meta_cur.oldest;
         match[w]  = ({1'b0, offs} < meta_cur.count) && (row_rd_ff[w].key == key_ff);
         hit_label = hit_label | (row_rd_ff[w].label & {LBL_W{match[w]}});
      end
   end

   assign hit = |match;

   always_comb begin
      meta_wr = meta_cur;
      if (meta_cur.count < CNT_W'(WAYS)) begin
         ins_way       = meta_cur.oldest + meta_cur.count[WAY_W-1:0];
         meta_wr.count = meta_cur.count + CNT_W'(1);
      end else begin
         ins_way        = meta_cur.oldest;
         meta_wr.oldest = meta_cur.oldest + WAY_W'(1);
      end
      row_wr                = row_rd_ff;
      row_wr[ins_way].key   = key_ff;
      row_wr[ins_way].label = fill_label_ff;
   end

   assign sts.hit  = hit;
   assign sts.func = func_ff;

   always_comb begin
      found_in = found_ff;
      label_in = label_ff;
      if (cmd.commit) begin
         found_in = 1'b0;
         label_in = '0;
         if ((func_ff == FUNC_LOOKUP) || (func_ff == FUNC_FILL)) begin
            if (hit) begin
               found_in = 1'b1;
               label_in = hit_label;
            end else if (func_ff == FUNC_FILL) begin
               label_in = fill_label_ff;
            end
         end
      end
   end

   always_comb begin
      meta_valid_in = meta_valid_ff;
      if (cmd.flush) begin
         meta_valid_in = '0;
      end else if (cmd.wr_fill) begin
         meta_valid_in[bkt_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_valid_ff <= '0;
      end else begin
         meta_valid_ff <= meta_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         func_ff       <= req_func;
         key_ff        <= {req_protocol, req_port};
         bkt_ff        <= req_port[BKT_W-1:0];
         fill_label_ff <= req_fill_label;
         mvalid_ff     <= meta_valid_ff[req_port[BKT_W-1:0]];
      end
      found_ff <= found_in;
      label_ff <= label_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         row_rd_ff <= mem_rows[req_port[BKT_W-1:0]];
      end
      if (cmd.wr_fill) begin
         mem_rows[bkt_ff] <= row_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         meta_rd_ff <= mem_meta[req_port[BKT_W-1:0]];
      end
      if (cmd.wr_fill) begin
         mem_meta[bkt_ff] <= meta_wr;
      end
   end

   assign rsp_found = found_ff;
   assign rsp_label = label_ff;

endmodule

[hdl/port_label_cache.sv]
// The bucket row read for a request word is registered, then compared across all
// ways; the result word is registered once no earlier result word is stalled.
// A new request word is not taken until the previous one has finished the
// bucket-row memory read, the all-way compare and fill write-back of the same row.
// Reset (synchronous, active high): per-bucket valid flags clear at once, so all
// buckets read empty; no clearing pass. Entry stores are not reset.
module port_label_cache
   import plc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PROTO_W-1:0] req_protocol,
   input  logic [PORT_W-1:0]  req_port,
   input  logic [LBL_W-1:0]   req_fill_label,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [LBL_W-1:0]   rsp_label
);

   cmd_type cmd;
   sts_type sts;

   plc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   plc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_protocol   (req_protocol),
      .req_port       (req_port),
      .req_fill_label (req_fill_label),
      .rsp_found      (rsp_found),
      .rsp_label      (rsp_label)
   );

endmodule

[hdl/plc_checker.sv]
module plc_props
   import plc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [FUNC_W-1:0]  req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_found,
   input logic [LBL_W-1:0]   rsp_label
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_label))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in flight");

   a_flush_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == FUNC_FLUSH)) ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid && !rsp_found && (rsp_label == '0))
      else $error("flush response not zero");

endmodule

bind port_label_cache plc_props u_chk (.*);

[verif/plc_checker.sv]
`timescale 1ns / 1ps

module plc_checker
   import plc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PROTO_W-1:0] req_protocol,
   input  logic [PORT_W-1:0]  req_port,
   input  logic [LBL_W-1:0]   req_fill_label,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_found,
   input  logic [LBL_W-1:0]   rsp_label,
   output int                 fail_count,
   output int                 words_pending
);

   typedef struct packed {
      logic             found;
      logic [LBL_W-1:0] label;
   } label_word_type;

   label_word_type   expected_labels[$];
   label_word_type   head_word;
   logic [KEY_W-1:0] key_store   [BUCKETS*WAYS];
   logic [LBL_W-1:0] label_store [BUCKETS*WAYS];
   int               fill_level  [BUCKETS];
   int               oldest_way  [BUCKETS];
   int               mismatches = 0;

   task automatic report(input string what, input logic [LBL_W-1:0] want,
                         input logic [LBL_W-1:0] got);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   function automatic int find_slot(input int bkt, input logic [KEY_W-1:0] key);
      int way;
      way = oldest_way[bkt];
      for (int i = 0; i < fill_level[bkt]; i++) begin
         if (key_store[bkt*WAYS + way] == key)
            return bkt*WAYS + way;
         way = (way + 1) % WAYS;
      end
      return -1;
   endfunction

   // updates the cache image and returns the word the block must produce
   function automatic label_word_type cache_access(input logic [FUNC_W-1:0]  func,
                                                   input logic [PROTO_W-1:0] protocol,
                                                   input logic [PORT_W-1:0]  port,
                                                   input logic [LBL_W-1:0]   fill_label);
      label_word_type   word;
      logic [KEY_W-1:0] key;
      int               bkt;
      int               slot;
      int               way;
      word = '0;
      key  = {protocol, port};
      bkt  = port % BUCKETS;
      case (func)
         FUNC_LOOKUP, FUNC_FILL: begin
            slot = find_slot(bkt, key);
            if (slot >= 0) begin
               word.found = 1'b1;
               word.label = label_store[slot];
            end else if (func == FUNC_FILL) begin
               if (fill_level[bkt] < WAYS) begin
                  way = (oldest_way[bkt] + fill_level[bkt]) % WAYS;
                  fill_level[bkt]++;
               end else begin
                  way = oldest_way[bkt];
                  oldest_way[bkt] = (way + 1) % WAYS;
               end
               key_store[bkt*WAYS + way]   = key;
               label_store[bkt*WAYS + way] = fill_label;
               word.label = fill_label;
            end
         end
         FUNC_FLUSH: begin
            for (int b = 0; b < BUCKETS; b++) begin
               fill_level[b] = 0;
               oldest_way[b] = 0;
            end
         end
         default: ;
      endcase
      return word;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_labels.delete();
         for (int b = 0; b < BUCKETS; b++) begin
            fill_level[b] = 0;
            oldest_way[b] = 0;
         end
      end else begin
         // a word leaving now belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_labels.size() == 0) begin
               report("unexpected word", '0, rsp_label);
            end else begin
               head_word = expected_labels.pop_front();
               if (rsp_found !== head_word.found)
                  report("found", LBL_W'(head_word.found), LBL_W'(rsp_found));
               if (rsp_label !== head_word.label)
                  report("label", head_word.label, rsp_label);
            end
         end
         if (req_valid && !req_stall)
            expected_labels.push_back(cache_access(req_func, req_protocol, req_port,
                                                   req_fill_label));
      end
      fail_count    <= mismatches;
      words_pending <= expected_labels.size();
   end

endmodule

[verif/tb_port_label_cache.sv]
`timescale 1ns / 1ps

module tb_port_label_cache;
   import plc_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 700;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int SETTLE       = 10;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func;
   logic [PROTO_W-1:0] req_protocol;
   logic [PORT_W-1:0]  req_port;
   logic [LBL_W-1:0]   req_fill_label;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_found;
   logic [LBL_W-1:0]   rsp_label;
   int                 fail_count;
   int                 words_pending;
   int                 words_sent = 0;

   port_label_cache u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_protocol   (req_protocol),
      .req_port       (req_port),
      .req_fill_label (req_fill_label),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_label      (rsp_label)
   );

   plc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_protocol   (req_protocol),
      .req_port       (req_port),
      .req_fill_label (req_fill_label),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_label      (rsp_label),
      .fail_count     (fail_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_word(input logic [FUNC_W-1:0]  func,
                            input logic [PROTO_W-1:0] protocol,
                            input logic [PORT_W-1:0]  port,
                            input logic [LBL_W-1:0]   fill_label);
      int gap;
      // every third stretch of 50 words goes back to back
      gap = ((words_sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_protocol   <= protocol;
      req_port       <= port;
      req_fill_label <= fill_label;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // response side: random stalls, quiet stretches, and two long hold-offs
   initial begin
      int rsp_words;
      int stall_cycles;
      rsp_words = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_words == 150 || rsp_words == 480)
            stall_cycles = HOLD_CYCLES;
         else if ((rsp_words / 64) % 3 == 0)
            stall_cycles = 0;
         else
            stall_cycles = $urandom_range(0, 19);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         rsp_words++;
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("port_label_cache regression: fail");
      $finish;
   end

   initial begin
      logic [PROTO_W-1:0] protocol;
      logic [PORT_W-1:0]  port;
      logic [LBL_W-1:0]   fill_label;
      int                 roll;
      int                 waited;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= FUNC_LOOKUP;
      req_protocol   <= '0;
      req_port       <= '0;
      req_fill_label <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(FUNC_LOOKUP, 8'h00, 16'h0000, 32'h0);
      send_word(FUNC_FILL,   8'h00, 16'h0000, 32'h0);
      send_word(FUNC_LOOKUP, 8'h00, 16'h0000, 32'h0);
      send_word(FUNC_FILL,   8'h00, 16'h0000, 32'hFFFF_FFFF);
      send_word(FUNC_FILL,   8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(FUNC_LOOKUP, 8'hFF, 16'hFFFF, 32'h0);
      send_word(FUNC_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      // fill one bucket, then overflow it to evict the oldest
      for (int k = 0; k <= WAYS; k++)
         send_word(FUNC_FILL, 8'd17, {8'(k), 8'h12}, $urandom);
      send_word(FUNC_LOOKUP, 8'd17, 16'h0012, 32'h0);
      send_word(FUNC_LOOKUP, 8'd17, 16'h0112, 32'h0);
      send_word(FUNC_FLUSH,  8'd17, 16'h0112, 32'h0);
      send_word(FUNC_LOOKUP, 8'd17, 16'h0112, 32'h0);

      while (words_sent < RANDOM_WORDS + 28) begin
         if ($urandom_range(0, 9) < 7) begin
            protocol = $urandom_range(0, 1) ? 8'd6 : 8'd17;
            port     = {8'($urandom_range(0, 11)), 8'($urandom_range(0, 3) * 37)};
         end else begin
            protocol = $urandom;
            port     = $urandom;
         end
         fill_label = $urandom;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            send_word(FUNC_FLUSH, protocol, port, fill_label);
         end else if (roll < 4) begin
            send_word(FUNC_UNUSED, protocol, port, fill_label);
         end else if (roll < 10) begin
            send_word(FUNC_FILL, protocol, port, fill_label);
         end else begin
            send_word(FUNC_LOOKUP, protocol, port, $urandom);
            if ($urandom_range(0, 9) < 7)
               send_word(FUNC_FILL, protocol, port, fill_label);
         end
      end
      req_valid <= 1'b0;

      // let the pending count see the last accepted word
      @(posedge clock);
      waited = 0;
      while (words_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0 && words_pending == 0) begin
         $display("port_label_cache regression: pass");
      end else begin
         $display("port_label_cache regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
hdl/plc_pkg.sv
hdl/plc_ctrl.sv
hdl/plc_datapath.sv
hdl/port_label_cache.sv
hdl/plc_checker.sv
verif/plc_checker.sv
verif/tb_port_label_cache.sv
